FILE: rtl/core/pxq_pkg.sv
// Shared types and codes for the Paxos proposer quorum unit.
// Request and result structs, message and action codes, register map.
// No dependencies.
`default_nettype none

package pxq_pkg;

    // Default acceptor group capacity.
    localparam int MAX_NODES_DEF = 16;

    // Configuration port address width (two 32-bit registers).
    localparam int PADDR_W = 3;

    // Register indexes, taken from paddr[2].
    localparam logic REG_OWN_NODE   = 1'b0;
    localparam logic REG_NODE_COUNT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [3:0] OWN_NODE_RST   = 4'd0;
    localparam logic [4:0] NODE_COUNT_RST = 5'd3;

    // Input action codes.
    localparam logic [1:0] ACT_SUBMIT  = 2'd0;
    localparam logic [1:0] ACT_PROMISE = 2'd1;
    localparam logic [1:0] ACT_DENIAL  = 2'd2;

    // Emitted message kinds.
    localparam logic [1:0] KIND_PREPARE  = 2'd0;
    localparam logic [1:0] KIND_ACCEPT   = 2'd1;
    localparam logic [1:0] KIND_RESUBMIT = 2'd2;

    // One incoming request.
    typedef struct packed {
        logic [1:0]  action;
        logic        learned_flag;
        logic [3:0]  from_node;
        logic [31:0] prepare_number;
        logic [31:0] accepted_number;
        logic [31:0] value_in;
    } t_in_req;

    // One emitted message.
    typedef struct packed {
        logic [1:0]  msg_kind;
        logic [31:0] msg_number;
        logic [31:0] msg_value;
    } t_out_req;

    // Configuration write strobe from the bus interface.
    typedef struct packed {
        logic       wr;
        logic       sel;
        logic [4:0] data;
    } t_cfg_wr;

    // Current configuration, for read-back.
    typedef struct packed {
        logic [3:0] own_node;
        logic [4:0] node_count;
    } t_cfg;

endpackage : pxq_pkg

`default_nettype wire

FILE: rtl/core/pxq_engine.sv
// Proposer state engine: round number, best accepted value, vote bitmaps.
// Handles one request per cycle and decides the message it causes.
// Depends on pxq_pkg.
`default_nettype none

module pxq_engine #(
    parameter int MAX_NODES = pxq_pkg::MAX_NODES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pxq_pkg::t_cfg_wr  i_cfg_wr,
    output pxq_pkg::t_cfg          o_cfg,
    input  wire logic              i_go,
    input  wire pxq_pkg::t_in_req  i_req,
    output logic                   o_emit,
    output pxq_pkg::t_out_req      o_msg
);
    import pxq_pkg::*;

    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int MAJ_W = (CNT_W + 1 > 5) ? CNT_W + 1 : 5;

    logic [3:0]           r_own_node,      n_own_node;
    logic [4:0]           r_node_count,    n_node_count;
    logic [31:0]          r_current_number, n_current_number;
    logic [31:0]          r_best_acc,      n_best_acc;
    logic [31:0]          r_best_value,    n_best_value;
    logic [MAX_NODES-1:0] r_promised_map,  n_promised_map;
    logic [MAX_NODES-1:0] r_denied_map,    n_denied_map;
    logic                 r_round_started, n_round_started;

    logic [MAX_NODES-1:0] w_from_bit;
    logic                 w_hit;
    logic [CNT_W-1:0]     w_prom_cnt;
    logic [CNT_W-1:0]     w_deny_cnt;
    logic                 w_prom_maj;
    logic                 w_deny_maj;
    logic [31:0]          w_next_number;

    // One-hot select of the answering acceptor.
    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            w_from_bit[i] = (32'(i_req.from_node) == 32'(i));
        end
    end

    // The answer counts only for this round and from a sender inside the group.
    assign w_hit = (i_req.prepare_number == r_current_number)
                && ({1'b0, i_req.from_node} < r_node_count)
                && (32'(i_req.from_node) < 32'(MAX_NODES));

    // Vote counts after the current answer is recorded.
    always_comb begin
        w_prom_cnt = '0;
        w_deny_cnt = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            w_prom_cnt = w_prom_cnt + CNT_W'(r_promised_map[i] | w_from_bit[i]);
            w_deny_cnt = w_deny_cnt + CNT_W'(r_denied_map[i] | w_from_bit[i]);
        end
    end

    // Strict majority: twice the count exceeds the group size.
    assign w_prom_maj = MAJ_W'({w_prom_cnt, 1'b0}) > MAJ_W'(r_node_count);
    assign w_deny_maj = MAJ_W'({w_deny_cnt, 1'b0}) > MAJ_W'(r_node_count);

    assign w_next_number = r_current_number + 32'(r_node_count);

    // Next state and emitted message.
    always_comb begin
        n_own_node       = r_own_node;
        n_node_count     = r_node_count;
        n_current_number = r_current_number;
        n_best_acc       = r_best_acc;
        n_best_value     = r_best_value;
        n_promised_map   = r_promised_map;
        n_denied_map     = r_denied_map;
        n_round_started  = r_round_started;
        o_emit           = 1'b0;
        o_msg.msg_kind   = KIND_PREPARE;
        o_msg.msg_number = r_current_number;
        o_msg.msg_value  = i_req.value_in;

        // Configuration writes; before the first round the seed follows them.
        if (i_cfg_wr.wr) begin
            unique case (i_cfg_wr.sel)
                REG_OWN_NODE:   n_own_node   = i_cfg_wr.data[3:0];
                REG_NODE_COUNT: n_node_count = i_cfg_wr.data;
                default: ;
            endcase
            if (!r_round_started) begin
                n_current_number = 32'(n_own_node) + 32'(n_node_count);
            end
        end

        if (i_go) begin
            case (i_req.action)
                ACT_SUBMIT: begin
                    if (!i_req.learned_flag) begin
                        n_best_acc       = '0;
                        n_best_value     = i_req.value_in;
                        n_current_number = w_next_number;
                        n_promised_map   = '0;
                        n_denied_map     = '0;
                        n_round_started  = 1'b1;
                        o_emit           = 1'b1;
                        o_msg.msg_kind   = KIND_PREPARE;
                        o_msg.msg_number = w_next_number;
                        o_msg.msg_value  = i_req.value_in;
                    end
                end
                ACT_PROMISE: begin
                    if (w_hit) begin
                        if (i_req.accepted_number > r_best_acc) begin
                            n_best_acc   = i_req.accepted_number;
                            n_best_value = i_req.value_in;
                        end
                        n_promised_map = r_promised_map | w_from_bit;
                        if (w_prom_maj) begin
                            o_emit          = 1'b1;
                            o_msg.msg_kind  = KIND_ACCEPT;
                            o_msg.msg_value = n_best_value;
                        end
                    end
                end
                ACT_DENIAL: begin
                    if (w_hit) begin
                        n_denied_map = r_denied_map | w_from_bit;
                        if (w_deny_maj) begin
                            o_emit          = 1'b1;
                            o_msg.msg_kind  = KIND_RESUBMIT;
                            o_msg.msg_value = i_req.value_in;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_node       <= OWN_NODE_RST;
            r_node_count     <= NODE_COUNT_RST;
            r_current_number <= 32'(OWN_NODE_RST) + 32'(NODE_COUNT_RST);
            r_best_acc       <= '0;
            r_best_value     <= '0;
            r_promised_map   <= '0;
            r_denied_map     <= '0;
            r_round_started  <= 1'b0;
        end else begin
            r_own_node       <= n_own_node;
            r_node_count     <= n_node_count;
            r_current_number <= n_current_number;
            r_best_acc       <= n_best_acc;
            r_best_value     <= n_best_value;
            r_promised_map   <= n_promised_map;
            r_denied_map     <= n_denied_map;
            r_round_started  <= n_round_started;
        end
    end

    assign o_cfg.own_node   = r_own_node;
    assign o_cfg.node_count = r_node_count;

`ifndef ASSERT_OFF
    // A new round always starts with empty vote bitmaps.
    a_submit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && i_req.action == ACT_SUBMIT && !i_req.learned_flag
        |=> r_promised_map == '0 && r_denied_map == '0)
        else $error("vote bitmaps not cleared by a new round");

    // The round number moves only on a submit or a configuration write.
    a_number_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_go && i_req.action == ACT_SUBMIT) && !i_cfg_wr.wr
        |=> $stable(r_current_number))
        else $error("round number changed without a submit");

    // A message is emitted only for a request that is being processed.
    a_emit_needs_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> i_go)
        else $error("message emitted without a request");

    // An accept or resubmit carries the number of the current round.
    a_reply_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit && o_msg.msg_kind != KIND_PREPARE
        |-> o_msg.msg_number == r_current_number && w_hit)
        else $error("reply emitted for a foreign round");
`endif

endmodule : pxq_engine

`default_nettype wire

FILE: rtl/core/paxos_proposer_quorum_unit.sv
// Top level of the Paxos proposer quorum unit.
// Request input register, result register and configuration port around pxq_engine.
// Depends on pxq_pkg and pxq_engine.
//
// Usage:
//   Requests (submit, promise, denial) enter on i_in_valid / o_in_stall with
//   i_in_req; messages (PREPARE, ACCEPT, RESUBMIT) leave on o_out_valid /
//   i_out_stall with o_out_req. A request whose handshake completes is held
//   in an input register; once the result slot is free, the engine updates the
//   round state and, when the request causes a message, loads the result
//   register. Throughput is one request per cycle while the receiver does not
//   stall: the round state is read and written in that single cycle, so each
//   request sees everything its predecessor did. When the receiver stalls, the
//   pending message holds in the result register; one more request is still
//   taken into the input register and o_in_stall rises only while that request
//   is waiting for the result slot. A held request waits for the result slot
//   even when it causes no message. own_node (address 0) and node_count
//   (address 4) are written through the APB-style port; the user must do so
//   only while the block is idle, which the block does not enforce. pready is
//   always high. Synchronous reset empties both registers, sets own_node to 0,
//   node_count to 3 and the round number to their sum, and clears the vote bitmaps.
`default_nettype none

module paxos_proposer_quorum_unit #(
    parameter int MAX_NODES = pxq_pkg::MAX_NODES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Request channel.
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire pxq_pkg::t_in_req              i_in_req,
    // Message channel.
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output pxq_pkg::t_out_req                  o_out_req,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pxq_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import pxq_pkg::*;

    logic     r_in_valid,  n_in_valid;
    t_in_req  r_in_req;
    logic     r_out_valid, n_out_valid;
    t_out_req r_out_req;

    logic     w_in_acc;
    logic     w_out_free;
    logic     w_go;
    logic     w_emit;
    t_out_req w_msg;
    t_cfg_wr  w_cfg_wr;
    t_cfg     w_cfg;

    // Handshake control.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_go       = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Configuration write strobe and read-back.
    assign pready        = 1'b1;
    assign w_cfg_wr.wr   = psel && penable && pwrite;
    assign w_cfg_wr.sel  = paddr[2];
    assign w_cfg_wr.data = pwdata[4:0];

    always_comb begin
        unique case (paddr[2])
            REG_OWN_NODE:   prdata = 32'(w_cfg.own_node);
            REG_NODE_COUNT: prdata = 32'(w_cfg.node_count);
            default:        prdata = '0;
        endcase
    end

    pxq_engine #(
        .MAX_NODES (MAX_NODES)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (w_cfg_wr),
        .o_cfg    (w_cfg),
        .i_go     (w_go),
        .i_req    (r_in_req),
        .o_emit   (w_emit),
        .o_msg    (w_msg)
    );

    // Occupancy of the input and result registers.
    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_acc) begin
            n_in_valid = 1'b1;
        end else if (w_go) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (w_go && w_emit) begin
            n_out_valid = 1'b1;
        end else if (w_out_free) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_req <= i_in_req;
        end
        if (w_go && w_emit) begin
            r_out_req <= w_msg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

`ifndef ASSERT_OFF
    // A held request that cannot move stays in the input register.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_out_free |=> r_in_valid)
        else $error("held request lost");

    // A new message is loaded only into a free result register.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && w_emit |-> w_out_free)
        else $error("result register overwritten");

    // The input is refused only while a request is waiting.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && o_out_valid)
        else $error("input stalled without a waiting request");
`endif

endmodule : paxos_proposer_quorum_unit

`default_nettype wire

FILE: test/paxos_proposer_quorum_unit_test.sv
// Self-checking testbench for the Paxos proposer quorum unit.
// It drives requests and register writes, predicts every message and compares it.
// Depends on pxq_pkg and paxos_proposer_quorum_unit.
`default_nettype none

module paxos_proposer_quorum_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pxq_pkg::*;

    // Action code that the block must ignore.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Clock, reset and block inputs, all known from time zero.
    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_req              in_req    = '0;
    logic                 out_stall = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [31:0]          pwdata    = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_req             o_out_req;
    logic [31:0]          prdata;
    logic                 pready;

    // Predicted proposer state and configuration.
    logic [3:0]           cfg_own;
    logic [4:0]           cfg_count;
    logic [31:0]          round_num;
    logic [31:0]          best_acc_num;
    logic [31:0]          best_val;
    logic [15:0]          promise_map;
    logic [15:0]          deny_map;
    logic                 accept_sent;
    logic                 round_open;

    // Messages predicted but not yet seen at the output.
    t_out_req             pending_msgs[$];
    t_out_req             head_msg;

    // Pacing and bookkeeping.
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   sent_count     = 0;
    int                   msg_count      = 0;
    int                   mismatch_count = 0;
    int                   config_count   = 0;

    paxos_proposer_quorum_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (o_out_req),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge i_clk) begin
        out_stall <= i_rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // Compare each delivered message with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            msg_count++;
            if (pending_msgs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected message: kind %0d number %h value %h",
                             o_out_req.msg_kind, o_out_req.msg_number, o_out_req.msg_value);
                end
            end else begin
                head_msg = pending_msgs.pop_front();
                if (o_out_req.msg_kind !== head_msg.msg_kind ||
                    o_out_req.msg_number !== head_msg.msg_number ||
                    o_out_req.msg_value !== head_msg.msg_value) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Mismatch: kind %0d/%0d number %h/%h value %h/%h (exp/act)",
                                 head_msg.msg_kind, o_out_req.msg_kind,
                                 head_msg.msg_number, o_out_req.msg_number,
                                 head_msg.msg_value, o_out_req.msg_value);
                    end
                end
            end
        end
    end

    // Advance the predicted round state by one accepted request.
    function automatic void predict_request(input t_in_req r);
        logic [15:0] sender_bit;
        t_out_req    msg;
        if (r.action == ACT_SUBMIT) begin
            if (!r.learned_flag) begin
                best_acc_num = '0;
                best_val     = r.value_in;
                round_num    = round_num + cfg_count;
                promise_map  = '0;
                deny_map     = '0;
                accept_sent  = 1'b0;
                round_open   = 1'b1;
                msg.msg_kind   = KIND_PREPARE;
                msg.msg_number = round_num;
                msg.msg_value  = r.value_in;
                pending_msgs.push_back(msg);
            end
        end else if ((r.action == ACT_PROMISE || r.action == ACT_DENIAL) &&
                     r.prepare_number == round_num && {1'b0, r.from_node} < cfg_count) begin
            sender_bit = 16'd1 << r.from_node;
            if (r.action == ACT_PROMISE) begin
                // Keep the value of the highest accepted number reported.
                if (r.accepted_number > best_acc_num) begin
                    best_acc_num = r.accepted_number;
                    best_val     = r.value_in;
                end
                promise_map = promise_map | sender_bit;
                if ($countones(promise_map) * 2 > cfg_count) begin
                    accept_sent    = 1'b1;
                    msg.msg_kind   = KIND_ACCEPT;
                    msg.msg_number = round_num;
                    msg.msg_value  = best_val;
                    pending_msgs.push_back(msg);
                end
            end else begin
                deny_map = deny_map | sender_bit;
                if ($countones(deny_map) * 2 > cfg_count) begin
                    msg.msg_kind   = KIND_RESUBMIT;
                    msg.msg_number = round_num;
                    msg.msg_value  = r.value_in;
                    pending_msgs.push_back(msg);
                end
            end
        end
    endfunction

    // Random request with a promise action and no learned flag; callers overwrite the fields they care about.
    function automatic t_in_req random_request();
        t_in_req r;
        r.action          = ACT_PROMISE;
        r.learned_flag    = 1'b0;
        r.from_node       = 4'($urandom_range(15));
        r.prepare_number  = $urandom;
        r.accepted_number = ($urandom_range(1) == 0) ? 32'($urandom_range(15)) : $urandom;
        r.value_in        = $urandom;
        return r;
    endfunction

    function automatic t_in_req make_request(input logic [1:0] act, input logic learned,
                                             input logic [3:0] from, input logic [31:0] prep,
                                             input logic [31:0] acc, input logic [31:0] val);
        t_in_req r;
        r.action          = act;
        r.learned_flag    = learned;
        r.from_node       = from;
        r.prepare_number  = prep;
        r.accepted_number = acc;
        r.value_in        = val;
        return r;
    endfunction

    // Offer one request, wait for the handshake, then maybe idle a while.
    task automatic send_request(input t_in_req req);
        in_req   <= req;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_request(req);
        sent_count++;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Hold off the sender until every predicted message has been delivered.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pending_msgs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write own_node then node_count in back-to-back bus transfers.
    task automatic load_config(input logic [3:0] own, input logic [4:0] count);
        logic [31:0] junk;
        settle_idle();
        junk    = $urandom;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_OWN_NODE, 2'b00};
        pwdata  <= {junk[27:0], own};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_own = own;
        if (!round_open) round_num = 32'(cfg_own) + 32'(cfg_count);
        penable <= 1'b0;
        paddr   <= {REG_NODE_COUNT, 2'b00};
        pwdata  <= {junk[31:5], count};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_count = count;
        if (!round_open) round_num = 32'(cfg_own) + 32'(cfg_count);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        config_count++;
    endtask

    task automatic set_pace(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
        endcase
    endtask

    // Promises on the reset round number, before any submit.
    task automatic test_reset_round();
        send_request(make_request(ACT_PROMISE, 1'b0, 4'd0, 32'd3, 32'd6, 32'h1234_5678));
        send_request(make_request(ACT_PROMISE, 1'b0, 4'd1, 32'd3, 32'd2, 32'h0BAD_F00D));
    endtask

    // Register writes before the first submit reseed the round number.
    task automatic test_seed_config();
        load_config(4'd15, 5'd16);
        send_request(make_request(ACT_DENIAL, 1'b0, 4'd15, 32'd31, 32'd0, 32'h0));
        load_config(4'd2, 5'd3);
        send_request(make_request(ACT_DENIAL, 1'b0, 4'd0, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    // A submit, then promises reaching and exceeding the majority.
    task automatic test_submit_quorum();
        send_request(make_request(ACT_SUBMIT, 1'b0, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF));
        send_request(make_request(ACT_PROMISE, 1'b0, 4'd2, round_num, 32'd7, 32'hAAAA_5555));
        send_request(make_request(ACT_PROMISE, 1'b0, 4'd0, round_num, 32'd0, 32'h5555_AAAA));
        send_request(make_request(ACT_PROMISE, 1'b0, 4'd1, round_num, 32'hFFFF_FFFF, 32'h0));
        // Repeated promise from a recorded sender emits ACCEPT again.
        send_request(make_request(ACT_PROMISE, 1'b0, 4'd1, round_num, 32'd1, 32'h1));
    endtask

    // Denials, including a repeated sender, reaching the majority.
    task automatic test_denial_quorum();
        send_request(make_request(ACT_SUBMIT, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0));
        send_request(make_request(ACT_DENIAL, 1'b0, 4'd0, round_num, 32'd0, 32'hDEAD_BEEF));
        send_request(make_request(ACT_DENIAL, 1'b0, 4'd0, round_num, 32'd0, 32'hCAFE_0001));
        send_request(make_request(ACT_DENIAL, 1'b0, 4'd2, round_num, 32'hFFFF_FFFF,
                                  32'h7FFF_FFFF));
    endtask

    // Requests the block must drop.
    task automatic test_ignored_requests();
        send_request(make_request(ACT_SUBMIT, 1'b1, 4'd3, 32'd0, 32'd0, 32'hFFFF_FFFF));
        send_request(make_request(ACT_UNUSED, 1'b1, 4'd0, round_num, 32'hFFFF_FFFF, 32'd9));
        send_request(make_request(ACT_PROMISE, 1'b0, 4'd0, round_num + 32'd1, 32'd5, 32'd5));
        send_request(make_request(ACT_PROMISE, 1'b0, 4'd3, round_num, 32'd5, 32'd5));
        send_request(make_request(ACT_DENIAL, 1'b0, 4'd15, round_num, 32'd0, 32'd0));
    endtask

    // Group sizes at the extremes, the zero size among them.
    task automatic test_count_extremes();
        load_config(4'd0, 5'd1);
        send_request(make_request(ACT_SUBMIT, 1'b0, 4'd0, 32'd0, 32'd0, 32'h0F0F_0F0F));
        send_request(make_request(ACT_PROMISE, 1'b0, 4'd0, round_num, 32'd3, 32'hF0F0_F0F0));
        load_config(4'd15, 5'd16);
        send_request(make_request(ACT_SUBMIT, 1'b0, 4'd8, 32'd0, 32'd0, 32'h0000_0001));
        send_request(make_request(ACT_PROMISE, 1'b0, 4'd15, round_num, 32'd1, 32'h8000_0000));
        load_config(4'd7, 5'd0);
        send_request(make_request(ACT_SUBMIT, 1'b0, 4'd0, 32'd0, 32'd0, 32'h1357_9BDF));
        send_request(make_request(ACT_PROMISE, 1'b0, 4'd0, round_num, 32'd1, 32'h2468_ACE0));
    endtask

    // Rounds of well-formed answers with random content, mixed with noise.
    task automatic test_random_rounds(input int target);
        int         done;
        int         phase;
        int         answers;
        int         deny_pct;
        int         roll;
        logic [4:0] count;
        t_in_req    req;
        done  = 0;
        phase = 0;
        while (done < target) begin
            // New setting and pace every so often; the drain before it is the pause.
            if (done >= phase * (target / 8)) begin
                roll = $urandom_range(9);
                count = (roll < 7) ? 5'($urandom_range(5, 1)) :
                        (roll < 9) ? 5'($urandom_range(15, 6)) : 5'd16;
                load_config(4'($urandom_range(15)), count);
                set_pace(phase);
                phase++;
            end
            req = random_request();
            req.action       = ACT_SUBMIT;
            req.learned_flag = ($urandom_range(9) == 0);
            send_request(req);
            done++;
            answers  = $urandom_range(cfg_count + 3, 1);
            deny_pct = $urandom_range(99);
            for (int k = 0; k < answers; k++) begin
                req  = random_request();
                roll = $urandom_range(99);
                if (roll < 80) begin
                    req.action         = ($urandom_range(99) < deny_pct) ? ACT_DENIAL
                                                                         : ACT_PROMISE;
                    req.prepare_number = round_num;
                    req.from_node      = 4'($urandom_range(cfg_count - 1));
                end else begin
                    case ($urandom_range(3))
                        0: req.prepare_number = round_num + 32'($urandom_range(40, 1));
                        1: begin
                            if (cfg_count < 16) req.from_node = 4'($urandom_range(15, cfg_count));
                            req.prepare_number = round_num;
                        end
                        2: req.action = ACT_UNUSED;
                        default: begin
                            req.action       = ACT_SUBMIT;
                            req.learned_flag = 1'b1;
                        end
                    endcase
                end
                send_request(req);
                done++;
            end
        end
    endtask

    // Main sequence.
    initial begin
        cfg_own      = OWN_NODE_RST;
        cfg_count    = NODE_COUNT_RST;
        round_num    = 32'(OWN_NODE_RST) + 32'(NODE_COUNT_RST);
        best_acc_num = '0;
        best_val     = '0;
        promise_map  = '0;
        deny_map     = '0;
        accept_sent  = 1'b0;
        round_open   = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        set_pace(3);
        test_reset_round();
        test_seed_config();
        test_submit_quorum();
        test_denial_quorum();
        test_ignored_requests();
        test_count_extremes();
        test_random_rounds(700);

        settle_idle();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d requests and checked %0d messages over %0d register settings,",
                 sent_count, msg_count, config_count);
        $display("covering submits, promise and denial quorums, stale answers and noise.");
        if (mismatch_count == 0 && pending_msgs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d messages missing", mismatch_count, pending_msgs.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("Timeout with %0d messages outstanding", pending_msgs.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule : paxos_proposer_quorum_unit_test

`default_nettype wire
